FILE: sv/bse_pkg.sv
package bse_pkg;

   localparam int WORD_W      = 32;
   localparam int VALUE_W     = 31;
   localparam int TOKEN_W     = VALUE_W + 2 - 1;
   localparam int PROG_DEPTH  = 256;
   localparam int PROG_AW     = $clog2(PROG_DEPTH);
   localparam int LEN_W       = PROG_AW + 1;
   localparam int STACK_DEPTH = 256;
   localparam int STACK_AW    = $clog2(STACK_DEPTH);
   localparam int SENSOR_W    = 8;
   localparam int DIV_CNT_W   = $clog2(WORD_W) + 1;

   // opcode letters
   localparam logic [VALUE_W-1:0] OP_TICK = VALUE_W'(8'h61);
   localparam logic [VALUE_W-1:0] OP_PUT  = VALUE_W'(8'h62);
   localparam logic [VALUE_W-1:0] OP_DROP = VALUE_W'(8'h63);
   localparam logic [VALUE_W-1:0] OP_MUL  = VALUE_W'(8'h64);
   localparam logic [VALUE_W-1:0] OP_DIV  = VALUE_W'(8'h65);
   localparam logic [VALUE_W-1:0] OP_ADD  = VALUE_W'(8'h66);
   localparam logic [VALUE_W-1:0] OP_SUB  = VALUE_W'(8'h67);
   localparam logic [VALUE_W-1:0] OP_MOD  = VALUE_W'(8'h68);
   localparam logic [VALUE_W-1:0] OP_SHL  = VALUE_W'(8'h6a);
   localparam logic [VALUE_W-1:0] OP_SHR  = VALUE_W'(8'h6b);
   localparam logic [VALUE_W-1:0] OP_AND  = VALUE_W'(8'h6c);
   localparam logic [VALUE_W-1:0] OP_OR   = VALUE_W'(8'h6d);
   localparam logic [VALUE_W-1:0] OP_XOR  = VALUE_W'(8'h6e);
   localparam logic [VALUE_W-1:0] OP_NOT  = VALUE_W'(8'h6f);
   localparam logic [VALUE_W-1:0] OP_DUP  = VALUE_W'(8'h70);
   localparam logic [VALUE_W-1:0] OP_PICK = VALUE_W'(8'h71);
   localparam logic [VALUE_W-1:0] OP_SWAP = VALUE_W'(8'h72);
   localparam logic [VALUE_W-1:0] OP_LT   = VALUE_W'(8'h73);
   localparam logic [VALUE_W-1:0] OP_GT   = VALUE_W'(8'h74);
   localparam logic [VALUE_W-1:0] OP_EQ   = VALUE_W'(8'h75);
   localparam logic [VALUE_W-1:0] OP_AX   = VALUE_W'(8'h58);
   localparam logic [VALUE_W-1:0] OP_AY   = VALUE_W'(8'h59);
   localparam logic [VALUE_W-1:0] OP_AZ   = VALUE_W'(8'h5a);
   localparam logic [VALUE_W-1:0] OP_P1X  = VALUE_W'(8'h78);
   localparam logic [VALUE_W-1:0] OP_P1Y  = VALUE_W'(8'h79);
   localparam logic [VALUE_W-1:0] OP_P2X  = VALUE_W'(8'h76);
   localparam logic [VALUE_W-1:0] OP_P2Y  = VALUE_W'(8'h77);

   // request modes
   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_APPEND = 2'd1;
   localparam logic [1:0] MODE_EVAL   = 2'd2;

   // token classes
   localparam logic [3:0] C_NOP  = 4'd0;
   localparam logic [3:0] C_LIT  = 4'd1;
   localparam logic [3:0] C_IN   = 4'd2;
   localparam logic [3:0] C_BIN  = 4'd3;
   localparam logic [3:0] C_DIV  = 4'd4;
   localparam logic [3:0] C_PUT  = 4'd5;
   localparam logic [3:0] C_DROP = 4'd6;
   localparam logic [3:0] C_NOT  = 4'd7;
   localparam logic [3:0] C_DUP  = 4'd8;
   localparam logic [3:0] C_PICK = 4'd9;
   localparam logic [3:0] C_SWAP = 4'd10;

   // stack write address select
   localparam logic [2:0] W_SP   = 3'd0;
   localparam logic [2:0] W_SPM1 = 3'd1;
   localparam logic [2:0] W_SPM2 = 3'd2;
   localparam logic [2:0] W_PUT  = 3'd3;
   localparam logic [2:0] W_CLR  = 3'd4;

   // stack write data select
   localparam logic [2:0] D_ZERO  = 3'd0;
   localparam logic [2:0] D_LIT   = 3'd1;
   localparam logic [2:0] D_IN    = 3'd2;
   localparam logic [2:0] D_ALU   = 3'd3;
   localparam logic [2:0] D_A     = 3'd4;
   localparam logic [2:0] D_B     = 3'd5;
   localparam logic [2:0] D_RDATA = 3'd6;

   // stack read address select
   localparam logic [1:0] R_SPM1 = 2'd0;
   localparam logic [1:0] R_SPM2 = 2'd1;
   localparam logic [1:0] R_PICK = 2'd2;

   // stack pointer update
   localparam logic [1:0] SP_HOLD = 2'd0;
   localparam logic [1:0] SP_INC  = 2'd1;
   localparam logic [1:0] SP_DEC  = 2'd2;

   typedef struct packed {
      logic       in_ld;
      logic       prog_clear;
      logic       prog_append;
      logic       pc_clr;
      logic       pc_inc;
      logic       tok_ld;
      logic       a_ld;
      logic       b_ld;
      logic       div_start;
      logic       out_ld;
      logic       clr_inc;
      logic       stk_we;
      logic [2:0] waddr_sel;
      logic [2:0] wdata_sel;
      logic [1:0] raddr_sel;
      logic [1:0] sp_op;
   } bse_cmd_type;

   typedef struct packed {
      logic       pc_end;
      logic [3:0] cls;
      logic       div_busy;
      logic       clr_done;
   } bse_status_type;

   function automatic logic [3:0] op_class(input logic is_op, input logic [VALUE_W-1:0] v);
      logic [3:0] c;
      c = C_NOP;
      if (!is_op) begin
         c = C_LIT;
      end else if (v == OP_TICK || v == OP_AX || v == OP_AY || v == OP_AZ
                   || v == OP_P1X || v == OP_P1Y || v == OP_P2X || v == OP_P2Y) begin
         c = C_IN;
      end else if (v == OP_MUL || v == OP_ADD || v == OP_SUB || v == OP_SHL
                   || v == OP_SHR || v == OP_AND || v == OP_OR || v == OP_XOR
                   || v == OP_LT || v == OP_GT || v == OP_EQ) begin
         c = C_BIN;
      end else if (v == OP_DIV || v == OP_MOD) begin
         c = C_DIV;
      end else if (v == OP_PUT) begin
         c = C_PUT;
      end else if (v == OP_DROP) begin
         c = C_DROP;
      end else if (v == OP_NOT) begin
         c = C_NOT;
      end else if (v == OP_DUP) begin
         c = C_DUP;
      end else if (v == OP_PICK) begin
         c = C_PICK;
      end else if (v == OP_SWAP) begin
         c = C_SWAP;
      end
      return c;
   endfunction

endpackage

FILE: sv/bse_ram.sv
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/bse_datapath.sv
module bse_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bse_pkg::bse_cmd_type                 cmd,
   output bse_pkg::bse_status_type              status,
   input  logic                                 req_token_is_op,
   input  logic [bse_pkg::VALUE_W-1:0]          req_token_value,
   input  logic signed [bse_pkg::WORD_W-1:0]    req_tick,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_accel_x,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_accel_y,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_accel_z,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_pad1_x,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_pad1_y,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_pad2_x,
   input  logic [bse_pkg::SENSOR_W-1:0]         req_pad2_y,
   output logic signed [bse_pkg::WORD_W-1:0]    rsp_sample,
   output logic [bse_pkg::STACK_AW-1:0]         rsp_stack_level
);

   localparam int W  = bse_pkg::WORD_W;
   localparam int SW = bse_pkg::SENSOR_W;
   localparam int AW = bse_pkg::STACK_AW;

   logic [AW-1:0]                   sp_ff, sp_in;
   logic [bse_pkg::LEN_W-1:0]       len_ff, len_in, pc_ff, pc_in;
   logic [AW-1:0]                   clr_ff, clr_in;
   logic [bse_pkg::TOKEN_W-1:0]     tok_ff, tok_in;
   logic [W-1:0]                    a_ff, a_in, b_ff, b_in;
   logic [W-1:0]                    tick_ff, tick_in;
   logic [SW-1:0]                   ax_ff, ay_ff, az_ff, p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic [SW-1:0]                   ax_in, ay_in, az_in, p1x_in, p1y_in, p2x_in, p2y_in;
   logic [W-1:0]                    sample_ff, sample_in;
   logic [AW-1:0]                   level_ff, level_in;
   logic [bse_pkg::DIV_CNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [W-1:0]                    rem_ff, rem_in, quot_ff, quot_in;
   logic                            dneg_ff, dneg_in;

   logic [bse_pkg::TOKEN_W-1:0]     prog_rdata;
   logic                            prog_we;
   logic [W-1:0]                    stk_rdata, stk_wdata;
   logic [AW-1:0]                   stk_waddr, stk_raddr;
   logic [AW-1:0]                   spm1, spm2;
   logic [W-1:0]                    in_push, alu;
   logic [2*W-1:0]                  prod;
   logic [W:0]                      rs, diff;
   logic [W-1:0]                    quot_res, rem_res, shl, shr;
   logic                            div_bad, big_shift;

   assign prog_we = cmd.prog_append && (len_ff < bse_pkg::LEN_W'(bse_pkg::PROG_DEPTH));

   bse_ram #(.WIDTH(bse_pkg::TOKEN_W), .DEPTH(bse_pkg::PROG_DEPTH)) u_prog (
      .clock   (clock),
      .wr_en   (prog_we),
      .wr_addr (len_ff[bse_pkg::PROG_AW-1:0]),
      .wr_data ({req_token_is_op, req_token_value}),
      .rd_addr (pc_ff[bse_pkg::PROG_AW-1:0]),
      .rd_data (prog_rdata)
   );

   bse_ram #(.WIDTH(W), .DEPTH(bse_pkg::STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (cmd.stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign spm1 = sp_ff - AW'(1);
   assign spm2 = sp_ff - AW'(2);

   always_comb begin
      unique case (cmd.raddr_sel)
         bse_pkg::R_SPM2: stk_raddr = spm2;
         bse_pkg::R_PICK: stk_raddr = spm2 - a_ff[AW-1:0];
         default:         stk_raddr = spm1;
      endcase
      unique case (cmd.waddr_sel)
         bse_pkg::W_SPM1: stk_waddr = spm1;
         bse_pkg::W_SPM2: stk_waddr = spm2;
         bse_pkg::W_PUT:  stk_waddr = spm2 - b_ff[AW-1:0];
         bse_pkg::W_CLR:  stk_waddr = clr_ff;
         default:         stk_waddr = sp_ff;
      endcase
   end

   // sensor and tick pushes decode from the word being dispatched
   always_comb begin
      unique case (prog_rdata[bse_pkg::VALUE_W-1:0])
         bse_pkg::OP_TICK: in_push = tick_ff;
         bse_pkg::OP_AX:   in_push = {{(W-SW){1'b0}}, ax_ff};
         bse_pkg::OP_AY:   in_push = {{(W-SW){1'b0}}, ay_ff};
         bse_pkg::OP_AZ:   in_push = {{(W-SW){1'b0}}, az_ff};
         bse_pkg::OP_P1X:  in_push = {{(W-SW){1'b0}}, p1x_ff};
         bse_pkg::OP_P1Y:  in_push = {{(W-SW){1'b0}}, p1y_ff};
         bse_pkg::OP_P2X:  in_push = {{(W-SW){1'b0}}, p2x_ff};
         bse_pkg::OP_P2Y:  in_push = {{(W-SW){1'b0}}, p2y_ff};
         default:          in_push = '0;
      endcase
   end

   assign prod      = b_ff * a_ff;
   assign big_shift = a_ff >= W'(W);
   assign shl       = a_ff[W-1] ? b_ff : (big_shift ? '0 : (b_ff << a_ff[$clog2(W)-1:0]));
   assign shr       = a_ff[W-1] ? b_ff
                    : (big_shift ? '0 : W'($signed(b_ff) >>> a_ff[$clog2(W)-1:0]));
   assign div_bad   = (a_ff == '0) || a_ff[W-1];
   assign quot_res  = dneg_ff ? (W'(0) - quot_ff) : quot_ff;
   assign rem_res   = dneg_ff ? (W'(0) - rem_ff) : rem_ff;

   always_comb begin
      unique case (tok_ff[bse_pkg::VALUE_W-1:0])
         bse_pkg::OP_MUL: alu = prod[W-1:0];
         bse_pkg::OP_ADD: alu = b_ff + a_ff;
         bse_pkg::OP_SUB: alu = b_ff - a_ff;
         bse_pkg::OP_SHL: alu = shl;
         bse_pkg::OP_SHR: alu = shr;
         bse_pkg::OP_AND: alu = b_ff & a_ff;
         bse_pkg::OP_OR:  alu = b_ff | a_ff;
         bse_pkg::OP_XOR: alu = b_ff ^ a_ff;
         bse_pkg::OP_NOT: alu = ~a_ff;
         bse_pkg::OP_LT:  alu = ($signed(b_ff) < $signed(a_ff)) ? '1 : '0;
         bse_pkg::OP_GT:  alu = ($signed(b_ff) > $signed(a_ff)) ? '1 : '0;
         bse_pkg::OP_EQ:  alu = (b_ff == a_ff) ? '1 : '0;
         bse_pkg::OP_DIV: alu = div_bad ? '0 : quot_res;
         bse_pkg::OP_MOD: alu = div_bad ? '0 : rem_res;
         default:         alu = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wdata_sel)
         bse_pkg::D_LIT:   stk_wdata = {{(W-bse_pkg::VALUE_W){1'b0}},
                                        prog_rdata[bse_pkg::VALUE_W-1:0]};
         bse_pkg::D_IN:    stk_wdata = in_push;
         bse_pkg::D_ALU:   stk_wdata = alu;
         bse_pkg::D_A:     stk_wdata = a_ff;
         bse_pkg::D_B:     stk_wdata = b_ff;
         bse_pkg::D_RDATA: stk_wdata = stk_rdata;
         default:          stk_wdata = '0;
      endcase
   end

   // restoring divider, one quotient bit per cycle
   assign rs   = {rem_ff, quot_ff[W-1]};
   assign diff = rs - {1'b0, a_ff};

   always_comb begin
      dcnt_in = dcnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dneg_in = dneg_ff;
      if (cmd.div_start) begin
         dcnt_in = bse_pkg::DIV_CNT_W'(W);
         rem_in  = '0;
         quot_in = b_ff[W-1] ? (W'(0) - b_ff) : b_ff;
         dneg_in = b_ff[W-1];
      end else if (dcnt_ff != '0) begin
         dcnt_in = dcnt_ff - bse_pkg::DIV_CNT_W'(1);
         if (!diff[W]) begin
            rem_in  = diff[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in  = rs[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      sp_in     = sp_ff;
      len_in    = len_ff;
      pc_in     = pc_ff;
      clr_in    = clr_ff;
      tok_in    = cmd.tok_ld ? prog_rdata : tok_ff;
      a_in      = cmd.a_ld ? stk_rdata : a_ff;
      b_in      = cmd.b_ld ? stk_rdata : b_ff;
      tick_in   = cmd.in_ld ? W'(req_tick) : tick_ff;
      ax_in     = cmd.in_ld ? req_accel_x : ax_ff;
      ay_in     = cmd.in_ld ? req_accel_y : ay_ff;
      az_in     = cmd.in_ld ? req_accel_z : az_ff;
      p1x_in    = cmd.in_ld ? req_pad1_x : p1x_ff;
      p1y_in    = cmd.in_ld ? req_pad1_y : p1y_ff;
      p2x_in    = cmd.in_ld ? req_pad2_x : p2x_ff;
      p2y_in    = cmd.in_ld ? req_pad2_y : p2y_ff;
      sample_in = cmd.out_ld ? stk_rdata : sample_ff;
      level_in  = cmd.out_ld ? sp_ff : level_ff;
      unique case (cmd.sp_op)
         bse_pkg::SP_INC: sp_in = sp_ff + AW'(1);
         bse_pkg::SP_DEC: sp_in = spm1;
         default:         sp_in = sp_ff;
      endcase
      if (cmd.prog_clear) begin
         len_in = '0;
      end else if (prog_we) begin
         len_in = len_ff + bse_pkg::LEN_W'(1);
      end
      if (cmd.pc_clr) begin
         pc_in = '0;
      end else if (cmd.pc_inc) begin
         pc_in = pc_ff + bse_pkg::LEN_W'(1);
      end
      if (cmd.clr_inc) begin
         clr_in = clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff   <= '0;
         len_ff  <= '0;
         pc_ff   <= '0;
         clr_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         sp_ff   <= sp_in;
         len_ff  <= len_in;
         pc_ff   <= pc_in;
         clr_ff  <= clr_in;
         dcnt_ff <= dcnt_in;
      end
      tok_ff    <= tok_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      tick_ff   <= tick_in;
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      az_ff     <= az_in;
      p1x_ff    <= p1x_in;
      p1y_ff    <= p1y_in;
      p2x_ff    <= p2x_in;
      p2y_ff    <= p2y_in;
      sample_ff <= sample_in;
      level_ff  <= level_in;
      rem_ff    <= rem_in;
      quot_ff   <= quot_in;
      dneg_ff   <= dneg_in;
   end

   assign status.pc_end   = (pc_ff == len_ff);
   assign status.cls      = bse_pkg::op_class(prog_rdata[bse_pkg::TOKEN_W-1],
                                              prog_rdata[bse_pkg::VALUE_W-1:0]);
   assign status.div_busy = (dcnt_ff != '0);
   assign status.clr_done = (clr_ff == '1);

   assign rsp_sample      = sample_ff;
   assign rsp_stack_level = level_ff;

endmodule

FILE: sv/bse_controller.sv
module bse_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [1:0]              req_mode,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bse_pkg::bse_cmd_type    cmd,
   input  bse_pkg::bse_status_type status
);

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_FETCH    = 5'd2;
   localparam logic [4:0] S_DISPATCH = 5'd3;
   localparam logic [4:0] S_RDB      = 5'd4;
   localparam logic [4:0] S_EXEC     = 5'd5;
   localparam logic [4:0] S_DIVS     = 5'd6;
   localparam logic [4:0] S_DIVW     = 5'd7;
   localparam logic [4:0] S_WRBIN    = 5'd8;
   localparam logic [4:0] S_UCAP     = 5'd9;
   localparam logic [4:0] S_UNOT     = 5'd10;
   localparam logic [4:0] S_UDUP     = 5'd11;
   localparam logic [4:0] S_PICK     = 5'd12;
   localparam logic [4:0] S_PICKWR   = 5'd13;
   localparam logic [4:0] S_PUTWR    = 5'd14;
   localparam logic [4:0] S_SWAP1    = 5'd15;
   localparam logic [4:0] S_SWAP2    = 5'd16;
   localparam logic [4:0] S_FIN      = 5'd17;
   localparam logic [4:0] S_FINCAP   = 5'd18;

   logic [4:0] state_ff, state_in;
   logic [3:0] cls_ff, cls_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      cls_in       = cls_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.raddr_sel = bse_pkg::R_SPM1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_CLR;
            cmd.wdata_sel = bse_pkg::D_ZERO;
            cmd.clr_inc   = 1'b1;
            if (status.clr_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.in_ld = 1'b1;
               unique case (req_mode)
                  bse_pkg::MODE_CLEAR:  cmd.prog_clear = 1'b1;
                  bse_pkg::MODE_APPEND: cmd.prog_append = 1'b1;
                  bse_pkg::MODE_EVAL: begin
                     cmd.pc_clr = 1'b1;
                     state_in   = S_FETCH;
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            state_in = status.pc_end ? S_FIN : S_DISPATCH;
         end
         S_DISPATCH: begin
            cmd.tok_ld = 1'b1;
            cmd.pc_inc = 1'b1;
            cls_in     = status.cls;
            state_in   = S_FETCH;
            unique case (status.cls)
               bse_pkg::C_LIT, bse_pkg::C_IN: begin
                  cmd.stk_we    = 1'b1;
                  cmd.waddr_sel = bse_pkg::W_SP;
                  cmd.wdata_sel = (status.cls == bse_pkg::C_LIT) ? bse_pkg::D_LIT
                                                                 : bse_pkg::D_IN;
                  cmd.sp_op     = bse_pkg::SP_INC;
               end
               bse_pkg::C_DROP: cmd.sp_op = bse_pkg::SP_DEC;
               bse_pkg::C_BIN, bse_pkg::C_DIV, bse_pkg::C_PUT, bse_pkg::C_SWAP:
                  state_in = S_RDB;
               bse_pkg::C_NOT, bse_pkg::C_DUP, bse_pkg::C_PICK:
                  state_in = S_UCAP;
               default: ;
            endcase
         end
         S_RDB: begin
            cmd.a_ld      = 1'b1;
            cmd.raddr_sel = bse_pkg::R_SPM2;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.b_ld = 1'b1;
            unique case (cls_ff)
               bse_pkg::C_DIV:  state_in = S_DIVS;
               bse_pkg::C_PUT:  state_in = S_PUTWR;
               bse_pkg::C_SWAP: state_in = S_SWAP1;
               default:         state_in = S_WRBIN;
            endcase
         end
         S_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!status.div_busy) begin
               state_in = S_WRBIN;
            end
         end
         S_WRBIN: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SPM2;
            cmd.wdata_sel = bse_pkg::D_ALU;
            cmd.sp_op     = bse_pkg::SP_DEC;
            state_in      = S_FETCH;
         end
         S_UCAP: begin
            cmd.a_ld = 1'b1;
            unique case (cls_ff)
               bse_pkg::C_NOT: state_in = S_UNOT;
               bse_pkg::C_DUP: state_in = S_UDUP;
               default:        state_in = S_PICK;
            endcase
         end
         S_UNOT: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SPM1;
            cmd.wdata_sel = bse_pkg::D_ALU;
            state_in      = S_FETCH;
         end
         S_UDUP: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SP;
            cmd.wdata_sel = bse_pkg::D_A;
            cmd.sp_op     = bse_pkg::SP_INC;
            state_in      = S_FETCH;
         end
         S_PICK: begin
            cmd.raddr_sel = bse_pkg::R_PICK;
            state_in      = S_PICKWR;
         end
         S_PICKWR: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SPM1;
            cmd.wdata_sel = bse_pkg::D_RDATA;
            state_in      = S_FETCH;
         end
         S_PUTWR: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_PUT;
            cmd.wdata_sel = bse_pkg::D_A;
            cmd.sp_op     = bse_pkg::SP_DEC;
            state_in      = S_FETCH;
         end
         S_SWAP1: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SPM2;
            cmd.wdata_sel = bse_pkg::D_A;
            state_in      = S_SWAP2;
         end
         S_SWAP2: begin
            cmd.stk_we    = 1'b1;
            cmd.waddr_sel = bse_pkg::W_SPM1;
            cmd.wdata_sel = bse_pkg::D_B;
            state_in      = S_FETCH;
         end
         S_FIN: begin
            state_in = S_FINCAP;
         end
         S_FINCAP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_ff <= cls_in;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/bytebeat_stack_evaluator.sv
// Reverse-Polish bytebeat evaluator. Mode 0 empties the program, mode 1 appends one
// token (dropped once 256 are stored), mode 2 runs the program for one tick and returns
// the top of the 256-word wrapping stack plus the stack pointer; the stack persists
// across ticks. After reset the stack is zeroed in a sweep during which no word is
// accepted. Clear and append are done in the accepting cycle. An evaluation walks the
// program one token at a time through a single-port-read stack memory: a push, drop or
// unknown letter ends at dispatch, unary ops, binary ops, put and swap first read their
// operands, divide and modulo wait on the divider (one quotient bit per cycle), then the
// top is read out. A result still waiting for rsp_ready holds the next one back.
module bytebeat_stack_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_mode,
   input  logic                              req_token_is_op,
   input  logic [bse_pkg::VALUE_W-1:0]       req_token_value,
   input  logic signed [bse_pkg::WORD_W-1:0] req_tick,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_accel_x,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_accel_y,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_accel_z,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_pad1_x,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_pad1_y,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_pad2_x,
   input  logic [bse_pkg::SENSOR_W-1:0]      req_pad2_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bse_pkg::WORD_W-1:0] rsp_sample,
   output logic [bse_pkg::STACK_AW-1:0]      rsp_stack_level
);

   bse_pkg::bse_cmd_type    cmd;
   bse_pkg::bse_status_type status;

   bse_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   bse_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_token_is_op (req_token_is_op),
      .req_token_value (req_token_value),
      .req_tick        (req_tick),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_pad1_x      (req_pad1_x),
      .req_pad1_y      (req_pad1_y),
      .req_pad2_x      (req_pad2_x),
      .req_pad2_y      (req_pad2_y),
      .rsp_sample      (rsp_sample),
      .rsp_stack_level (rsp_stack_level)
   );

endmodule

FILE: sv/bse_checker.sv
module bse_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_mode,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [bse_pkg::WORD_W-1:0] rsp_sample
);

   // a held result word keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("result word dropped or changed while stalled");

   // a result only appears at the end of an evaluation
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an evaluation");

   // clear, append and the unused mode return to idle in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode != bse_pkg::MODE_EVAL |=> req_ready)
      else $error("program edit did not return to idle");

   // evaluation holds off the next word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == bse_pkg::MODE_EVAL |=> !req_ready)
      else $error("word accepted during evaluation");

endmodule

bind bytebeat_stack_evaluator bse_checker u_bse_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_mode   (req_mode),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

FILE: bench/bytebeat_stack_evaluator_test.sv
`timescale 1ns / 100ps

module bytebeat_stack_evaluator_test;
   import bse_pkg::*;

   localparam logic [VALUE_W-1:0] OP_UNKNOWN = VALUE_W'(8'h69);
   localparam logic [1:0]         MODE_NONE  = 2'd3;
   localparam int                 HOLD_CYCLES = 500;
   localparam int                 WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      logic [1:0]                  mode;
      logic                        is_op;
      logic [VALUE_W-1:0]          value;
      logic [WORD_W-1:0]           tick;
      logic [6:0][SENSOR_W-1:0]    sens;
   } bb_word_type;

   typedef struct packed {
      logic [WORD_W-1:0]   sample;
      logic [STACK_AW-1:0] level;
   } bb_sample_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [1:0]                  req_mode;
   logic                        req_token_is_op;
   logic [VALUE_W-1:0]          req_token_value;
   logic signed [WORD_W-1:0]    req_tick;
   logic [SENSOR_W-1:0]         req_accel_x, req_accel_y, req_accel_z;
   logic [SENSOR_W-1:0]         req_pad1_x, req_pad1_y, req_pad2_x, req_pad2_y;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [WORD_W-1:0]    rsp_sample;
   logic [STACK_AW-1:0]         rsp_stack_level;

   // predictor state
   logic                        prog_is_op [PROG_DEPTH];
   logic [VALUE_W-1:0]          prog_value [PROG_DEPTH];
   int                          prog_len;
   logic [WORD_W-1:0]           stack_mem [STACK_DEPTH];
   logic [STACK_AW-1:0]         stack_ptr;
   bb_sample_type               expected_samples[$];

   int  error_count;
   int  words_sent;
   int  quiet_cycles;
   bit  sender_idles;
   bit  receiver_stalls;
   bit  hold_request;

   bytebeat_stack_evaluator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_token_is_op (req_token_is_op),
      .req_token_value (req_token_value),
      .req_tick        (req_tick),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .req_pad1_x      (req_pad1_x),
      .req_pad1_y      (req_pad1_y),
      .req_pad2_x      (req_pad2_x),
      .req_pad2_y      (req_pad2_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .rsp_stack_level (rsp_stack_level)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void stack_push(input logic [WORD_W-1:0] v);
      stack_mem[stack_ptr] = v;
      stack_ptr = stack_ptr + 1'b1;
   endfunction

   function automatic logic [WORD_W-1:0] stack_pop();
      stack_ptr = stack_ptr - 1'b1;
      return stack_mem[stack_ptr];
   endfunction

   function automatic void run_token_op(input logic [VALUE_W-1:0] op, input bb_word_type w);
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
      logic [STACK_AW-1:0] idx;
      case (op)
         OP_TICK: stack_push(w.tick);
         OP_PUT: begin
            a = stack_pop();
            b = stack_pop();
            stack_push(b);
            idx = stack_ptr - b[STACK_AW-1:0] - 1'b1;
            stack_mem[idx] = a;
         end
         OP_DROP: a = stack_pop();
         OP_DIV, OP_MOD: begin
            a = stack_pop();
            b = stack_pop();
            if ($signed(a) > 0) begin
               if (op == OP_DIV) stack_push($signed(b) / $signed(a));
               else stack_push($signed(b) % $signed(a));
            end else begin
               stack_push('0);
            end
         end
         OP_MUL, OP_ADD, OP_SUB, OP_SHL, OP_SHR, OP_AND, OP_OR, OP_XOR,
         OP_LT, OP_GT, OP_EQ: begin
            a = stack_pop();
            b = stack_pop();
            case (op)
               OP_MUL: stack_push(b * a);
               OP_ADD: stack_push(b + a);
               OP_SUB: stack_push(b - a);
               OP_SHL: stack_push(a[WORD_W-1] ? b : (a >= WORD_W) ? '0 : b << a);
               OP_SHR: stack_push(a[WORD_W-1] ? b
                                  : (a >= WORD_W) ? '0 : WORD_W'($signed(b) >>> a));
               OP_AND: stack_push(b & a);
               OP_OR:  stack_push(b | a);
               OP_XOR: stack_push(b ^ a);
               OP_LT:  stack_push(($signed(b) < $signed(a)) ? '1 : '0);
               OP_GT:  stack_push(($signed(b) > $signed(a)) ? '1 : '0);
               default: stack_push((b == a) ? '1 : '0);
            endcase
         end
         OP_NOT: begin
            a = stack_pop();
            stack_push(~a);
         end
         OP_DUP: begin
            a = stack_pop();
            stack_push(a);
            stack_push(a);
         end
         OP_PICK: begin
            a = stack_pop();
            idx = stack_ptr - a[STACK_AW-1:0] - 1'b1;
            stack_push(stack_mem[idx]);
         end
         OP_SWAP: begin
            a = stack_pop();
            b = stack_pop();
            stack_push(a);
            stack_push(b);
         end
         OP_AX:  stack_push(WORD_W'(w.sens[0]));
         OP_AY:  stack_push(WORD_W'(w.sens[1]));
         OP_AZ:  stack_push(WORD_W'(w.sens[2]));
         OP_P1X: stack_push(WORD_W'(w.sens[3]));
         OP_P1Y: stack_push(WORD_W'(w.sens[4]));
         OP_P2X: stack_push(WORD_W'(w.sens[5]));
         OP_P2Y: stack_push(WORD_W'(w.sens[6]));
         default: ;
      endcase
   endfunction

   function automatic void apply_word(input bb_word_type w);
      bb_sample_type s;
      case (w.mode)
         MODE_CLEAR: prog_len = 0;
         MODE_APPEND: begin
            if (prog_len < PROG_DEPTH) begin
               prog_is_op[prog_len] = w.is_op;
               prog_value[prog_len] = w.value;
               prog_len++;
            end
         end
         MODE_EVAL: begin
            for (int p = 0; p < prog_len; p++) begin
               if (prog_is_op[p]) run_token_op(prog_value[p], w);
               else stack_push(WORD_W'(prog_value[p]));
            end
            s.sample = stack_mem[stack_ptr - 1'b1];
            s.level  = stack_ptr;
            expected_samples.push_back(s);
         end
         default: ;
      endcase
   endfunction

   function automatic bb_word_type make_word(input logic [1:0] mode, input logic is_op,
                                             input logic [VALUE_W-1:0] value);
      bb_word_type w;
      w.mode  = mode;
      w.is_op = is_op;
      w.value = value;
      w.tick  = $urandom;
      for (int i = 0; i < 7; i++) w.sens[i] = SENSOR_W'($urandom_range(0, 255));
      return w;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_op(input int k);
      case (k)
         0:  return OP_TICK;
         1:  return OP_PUT;
         2:  return OP_DROP;
         3:  return OP_MUL;
         4:  return OP_DIV;
         5:  return OP_ADD;
         6:  return OP_SUB;
         7:  return OP_MOD;
         8:  return OP_SHL;
         9:  return OP_SHR;
         10: return OP_AND;
         11: return OP_OR;
         12: return OP_XOR;
         13: return OP_NOT;
         14: return OP_DUP;
         15: return OP_PICK;
         16: return OP_SWAP;
         17: return OP_LT;
         18: return OP_GT;
         19: return OP_EQ;
         20: return OP_AX;
         21: return OP_AY;
         22: return OP_AZ;
         23: return OP_P1X;
         24: return OP_P1Y;
         25: return OP_P2X;
         26: return OP_P2Y;
         27: return OP_UNKNOWN;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic bb_word_type random_token();
      logic [VALUE_W-1:0] v;
      if ($urandom_range(0, 9) < 6) return make_word(MODE_APPEND, 1'b1, pick_op($urandom_range(0, 28)));
      case ($urandom_range(0, 4))
         0, 1: v = VALUE_W'($urandom_range(0, 40));
         2: v = VALUE_W'($urandom);
         3: v = '1;
         default: v = '0;
      endcase
      return make_word(MODE_APPEND, 1'b0, v);
   endfunction

   task automatic send_word(input bb_word_type w);
      if (sender_idles && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= w.mode;
      req_token_is_op <= w.is_op;
      req_token_value <= w.value;
      req_tick        <= w.tick;
      req_accel_x     <= w.sens[0];
      req_accel_y     <= w.sens[1];
      req_accel_z     <= w.sens[2];
      req_pad1_x      <= w.sens[3];
      req_pad1_y      <= w.sens[4];
      req_pad2_x      <= w.sens[5];
      req_pad2_y      <= w.sens[6];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_word(w);
      words_sent++;
   endtask

   task automatic send_token(input logic is_op, input logic [VALUE_W-1:0] value);
      send_word(make_word(MODE_APPEND, is_op, value));
   endtask

   task automatic test_empty_program();
      send_word(make_word(MODE_CLEAR, 1'b0, '0));
      send_word(make_word(MODE_EVAL, 1'b0, '0));
   endtask

   task automatic test_sensors_and_tick();
      bb_word_type w;
      send_token(1'b1, OP_TICK);
      for (int k = 20; k <= 26; k++) send_token(1'b1, pick_op(k));
      w = make_word(MODE_EVAL, 1'b0, '0);
      w.tick = 32'h7fffffff;
      w.sens = '1;
      send_word(w);
      w.tick = 32'h80000000;
      w.sens = '0;
      send_word(w);
   endtask

   task automatic test_special_cases();
      send_word(make_word(MODE_CLEAR, 1'b0, '0));
      send_token(1'b0, 31'd9);
      send_token(1'b0, 31'd4);
      send_token(1'b1, OP_SUB);
      send_token(1'b0, 31'd0);
      send_token(1'b1, OP_MOD);
      send_token(1'b0, 31'd40);
      send_token(1'b1, OP_SHR);
      send_token(1'b1, OP_UNKNOWN);
      send_word(make_word(MODE_NONE, 1'b1, '1));
      send_word(make_word(MODE_EVAL, 1'b0, '0));
   endtask

   task automatic test_receiver_holdoff();
      send_word(make_word(MODE_CLEAR, 1'b0, '0));
      send_token(1'b1, OP_TICK);
      hold_request = 1'b1;
      repeat (8) send_word(make_word(MODE_EVAL, 1'b0, '0));
   endtask

   task automatic test_program_overflow();
      send_word(make_word(MODE_CLEAR, 1'b0, '0));
      repeat (PROG_DEPTH) send_word(random_token());
      send_token(1'b1, OP_NOT);
      send_token(1'b0, 31'd77);
      send_word(make_word(MODE_EVAL, 1'b0, '0));
   endtask

   task automatic test_random_programs(input int count);
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            send_word(make_word(MODE_CLEAR, 1'b0, '0));
            repeat ($urandom_range(1, 12)) send_word(random_token());
            repeat ($urandom_range(1, 3)) send_word(make_word(MODE_EVAL, 1'b0, '0));
         end else begin
            case ($urandom_range(0, 2))
               0: send_word(make_word(MODE_NONE, 1'($urandom), VALUE_W'($urandom)));
               1: send_word(random_token());
               default: send_word(make_word(MODE_EVAL, 1'b0, '0));
            endcase
         end
      end
   endtask

   // result side ready with random stalls and one long hold-off
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 10)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      bb_sample_type exp_s;
      if (rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample %h level %0d", $time, rsp_sample,
                     rsp_stack_level);
            error_count++;
         end else begin
            exp_s = expected_samples.pop_front();
            if (rsp_sample !== exp_s.sample) begin
               $display("%0t: sample expected %h actual %h", $time, exp_s.sample, rsp_sample);
               error_count++;
            end
            if (rsp_stack_level !== exp_s.level) begin
               $display("%0t: stack level expected %0d actual %0d", $time, exp_s.level,
                        rsp_stack_level);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("bytebeat_stack_evaluator verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_mode        <= MODE_CLEAR;
      req_token_is_op <= 1'b0;
      req_token_value <= '0;
      req_tick        <= '0;
      req_accel_x     <= '0;
      req_accel_y     <= '0;
      req_accel_z     <= '0;
      req_pad1_x      <= '0;
      req_pad1_y      <= '0;
      req_pad2_x      <= '0;
      req_pad2_y      <= '0;
      quiet_cycles    = 0;
      error_count     = 0;
      words_sent      = 0;
      hold_request    = 1'b0;
      sender_idles    = 1'b1;
      receiver_stalls = 1'b1;
      prog_len        = 0;
      stack_ptr       = '0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_mem[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_program();
      test_sensors_and_tick();
      test_special_cases();
      test_receiver_holdoff();
      test_program_overflow();
      test_random_programs(220);
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      test_random_programs(60);

      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("bytebeat_stack_evaluator verification clean");
      end else begin
         $display("bytebeat_stack_evaluator verification failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/bse_pkg.sv
sv/bse_ram.sv
sv/bse_datapath.sv
sv/bse_controller.sv
sv/bytebeat_stack_evaluator.sv
sv/bse_checker.sv
bench/bytebeat_stack_evaluator_test.sv
